/* hw/rtl/xcfd_pkg.sv */
// Package for the header/length frame deframer with XOR checksum.
// Holds sizes, result kinds, operation and register codes and the sequencer state type.
// No dependencies.
package xcfd_pkg;

  localparam int unsigned BufDepth   = 4096;
  localparam int unsigned AddrW      = $clog2(BufDepth);
  localparam int unsigned CntW       = AddrW + 1;
  localparam int unsigned DataW      = 8;
  localparam int unsigned LenW       = 12;
  localparam int unsigned TotW       = 2 * DataW + 1;
  localparam int unsigned MaxResults = 64;
  localparam int unsigned NumW       = $clog2(MaxResults + 1);
  localparam int unsigned HdrOvh     = 4;
  localparam int unsigned MinTotal   = 6;

  localparam logic [DataW-1:0] HeaderFirstRst  = 8'hFF;
  localparam logic [DataW-1:0] HeaderSecondRst = 8'hAA;

  typedef enum logic [1:0] {
    KindFrame    = 2'd0,
    KindRead     = 2'd1,
    KindOverflow = 2'd2
  } kind_e;

  typedef enum logic {
    OpPush = 1'b0,
    OpRead = 1'b1
  } op_e;

  typedef enum logic {
    CfgHeaderFirst  = 1'b0,
    CfgHeaderSecond = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StOvf,
    StRdOut,
    StScan,
    StHead0,
    StHead1,
    StLen0,
    StLen1,
    StCheck,
    StCopy,
    StFrame,
    StFinish
  } state_e;

endpackage

/* hw/rtl/xcfd_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Used for the receive buffer and the good-frame store. No dependencies.
module xcfd_ram #(
  parameter int unsigned AW = 12,
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* hw/rtl/xor_checked_frame_deframer_core.sv */
// A push stores its byte and runs the scan; a push into a full buffer reports overflow.
// The scan visits the circular receive buffer one byte per cycle over its single read port
// and pauses while a frame waits for output; it tests headers, then checks and copies frames.
// One transaction at a time; the output register lets the next one enter while a result waits.
// Reset clears counters, the head and scan pointers and control; buffer contents are undefined until written.
// Depends on xcfd_pkg and xcfd_ram.
module xor_checked_frame_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [11:0] read_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [11:0] frame_length_o,
  output logic [7:0]  read_data_o,
  output logic        last_o
);

  localparam int unsigned AW = xcfd_pkg::AddrW;
  localparam int unsigned CW = xcfd_pkg::CntW;
  localparam int unsigned DW = xcfd_pkg::DataW;
  localparam int unsigned TW = xcfd_pkg::TotW;
  localparam int unsigned NW = xcfd_pkg::NumW;

  xcfd_pkg::state_e state_q, state_d;

  logic [DW-1:0] hf_q, hs_q;
  logic [CW-1:0] fill_q, fill_d, s_q, s_d;
  logic [AW-1:0] head_q, head_d, k_q, k_d, tot_q, tot_d;
  logic [AW-1:0] good_len_q, good_len_d, pend_len_q, pend_len_d;
  logic          pend_q, pend_d;
  logic [NW-1:0] n_q, n_d;
  logic [DW-1:0] len_hi_q, len_hi_d, acc_q, acc_d;
  logic [AW-1:0] ridx_q, ridx_d;
  logic          cp_we_q, cp_we_d;
  logic [AW-1:0] cp_addr_q, cp_addr_d;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    kind_q, kind_d;
  logic [11:0]   flen_q, flen_d;
  logic [7:0]    rdata_q, rdata_d;
  logic          last_q, last_d;

  logic          rx_we;
  logic [AW-1:0] rx_waddr, rx_raddr, rx_off;
  logic [DW-1:0] rx_rd, st_rd;
  logic          st_re;

  logic [CW-1:0] avail;
  logic [TW-1:0] total;
  logic          slot_free, scan_done, hdr0_ok, hdr1_ok, total_big, total_wait, total_short;
  logic          ck_last, ck_acc, ck_good, copy_end;
  logic          accept;

  assign accept      = in_valid_i && (state_q == xcfd_pkg::StIdle);
  assign in_stall_o  = (state_q != xcfd_pkg::StIdle);
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign avail       = fill_q - s_q;
  assign scan_done   = (s_q >= fill_q) || (n_q == NW'(xcfd_pkg::MaxResults));
  assign hdr0_ok     = (rx_rd == hf_q);
  assign hdr1_ok     = (rx_rd == hs_q);
  assign total       = {1'b0, len_hi_q, rx_rd} + TW'(xcfd_pkg::HdrOvh);
  assign total_big   = total >= TW'(xcfd_pkg::BufDepth);
  assign total_wait  = total > TW'(avail);
  assign total_short = total < TW'(xcfd_pkg::MinTotal);
  assign ck_last     = (k_q == tot_q - AW'(3));
  assign ck_acc      = (k_q <= tot_q - AW'(5));
  assign ck_good     = (acc_q == rx_rd);
  assign copy_end    = (k_q == tot_q - AW'(1));

  always_comb begin
    rx_off = '0;
    case (state_q)
      xcfd_pkg::StHead0: rx_off = AW'(1);
      xcfd_pkg::StHead1: rx_off = AW'(2);
      xcfd_pkg::StLen0:  rx_off = AW'(3);
      xcfd_pkg::StLen1:  rx_off = AW'(2);
      xcfd_pkg::StCheck: rx_off = k_q + AW'(1);
      xcfd_pkg::StCopy:  rx_off = k_q;
      default:           rx_off = '0;
    endcase
  end

  assign rx_raddr = head_q + s_q[AW-1:0] + rx_off;
  assign rx_we    = accept && (operation_i == xcfd_pkg::OpPush) &&
                    (fill_q != CW'(xcfd_pkg::BufDepth));
  assign rx_waddr = head_q + fill_q[AW-1:0];
  assign st_re    = accept && (operation_i == xcfd_pkg::OpRead);

  xcfd_ram #(.AW(AW), .DW(DW)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_waddr),
    .wdata_i (rx_byte_i),
    .re_i    (1'b1),
    .raddr_i (rx_raddr),
    .rdata_o (rx_rd)
  );

  xcfd_ram #(.AW(AW), .DW(DW)) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (cp_we_q),
    .waddr_i (cp_addr_q),
    .wdata_i (rx_rd),
    .re_i    (st_re),
    .raddr_i (read_index_i[AW-1:0]),
    .rdata_o (st_rd)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      xcfd_pkg::StIdle: begin
        if (in_valid_i) begin
          if (operation_i == xcfd_pkg::OpRead) begin
            state_d = xcfd_pkg::StRdOut;
          end else if (fill_q == CW'(xcfd_pkg::BufDepth)) begin
            state_d = xcfd_pkg::StOvf;
          end else begin
            state_d = xcfd_pkg::StScan;
          end
        end
      end
      xcfd_pkg::StOvf, xcfd_pkg::StRdOut: begin
        if (slot_free) state_d = xcfd_pkg::StIdle;
      end
      xcfd_pkg::StScan: begin
        state_d = scan_done ? xcfd_pkg::StFinish : xcfd_pkg::StHead0;
      end
      xcfd_pkg::StHead0: begin
        if (!hdr0_ok) state_d = xcfd_pkg::StScan;
        else if (avail < CW'(2)) state_d = xcfd_pkg::StFinish;
        else state_d = xcfd_pkg::StHead1;
      end
      xcfd_pkg::StHead1: begin
        if (!hdr1_ok) state_d = xcfd_pkg::StScan;
        else if (avail < CW'(4)) state_d = xcfd_pkg::StFinish;
        else state_d = xcfd_pkg::StLen0;
      end
      xcfd_pkg::StLen0: state_d = xcfd_pkg::StLen1;
      xcfd_pkg::StLen1: begin
        if (total_big) state_d = xcfd_pkg::StScan;
        else if (total_wait) state_d = xcfd_pkg::StFinish;
        else if (total_short) state_d = xcfd_pkg::StScan;
        else state_d = xcfd_pkg::StCheck;
      end
      xcfd_pkg::StCheck: begin
        if (ck_last) state_d = ck_good ? xcfd_pkg::StCopy : xcfd_pkg::StScan;
      end
      xcfd_pkg::StCopy: begin
        if (copy_end) state_d = xcfd_pkg::StFrame;
      end
      xcfd_pkg::StFrame: begin
        if (!pend_q || slot_free) state_d = xcfd_pkg::StScan;
      end
      xcfd_pkg::StFinish: begin
        if (!pend_q || slot_free) state_d = xcfd_pkg::StIdle;
      end
      default: state_d = xcfd_pkg::StIdle;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    fill_d      = fill_q;
    s_d         = s_q;
    head_d      = head_q;
    k_d         = k_q;
    tot_d       = tot_q;
    good_len_d  = good_len_q;
    pend_d      = pend_q;
    pend_len_d  = pend_len_q;
    n_d         = n_q;
    len_hi_d    = len_hi_q;
    acc_d       = acc_q;
    ridx_d      = ridx_q;
    cp_we_d     = 1'b0;
    cp_addr_d   = cp_addr_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    flen_d      = flen_q;
    rdata_d     = rdata_q;
    last_d      = last_q;
    case (state_q)
      xcfd_pkg::StIdle: begin
        if (st_re) ridx_d = read_index_i[AW-1:0];
        if (rx_we) fill_d = fill_q + CW'(1);
      end
      xcfd_pkg::StOvf: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          kind_d      = xcfd_pkg::KindOverflow;
          flen_d      = '0;
          rdata_d     = '0;
          last_d      = 1'b1;
          fill_d      = '0;
          s_d         = '0;
        end
      end
      xcfd_pkg::StRdOut: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          kind_d      = xcfd_pkg::KindRead;
          flen_d      = 12'(good_len_q);
          rdata_d     = (ridx_q < good_len_q) ? st_rd : '0;
          last_d      = 1'b1;
        end
      end
      xcfd_pkg::StHead0: begin
        if (!hdr0_ok) s_d = s_q + CW'(1);
      end
      xcfd_pkg::StHead1: begin
        if (!hdr1_ok) s_d = s_q + CW'(1);
      end
      xcfd_pkg::StLen0: len_hi_d = rx_rd;
      xcfd_pkg::StLen1: begin
        tot_d = total[AW-1:0];
        acc_d = '0;
        k_d   = AW'(2);
        if (total_big || (!total_wait && total_short)) s_d = s_q + CW'(1);
      end
      xcfd_pkg::StCheck: begin
        if (ck_acc) acc_d = acc_q ^ rx_rd;
        k_d = k_q + AW'(1);
        if (ck_last) begin
          if (ck_good) k_d = '0;
          else s_d = s_q + CW'(1);
        end
      end
      xcfd_pkg::StCopy: begin
        cp_we_d   = 1'b1;
        cp_addr_d = k_q;
        k_d       = k_q + AW'(1);
      end
      xcfd_pkg::StFrame: begin
        if (!pend_q || slot_free) begin
          if (pend_q) begin
            out_valid_d = 1'b1;
            kind_d      = xcfd_pkg::KindFrame;
            flen_d      = 12'(pend_len_q);
            rdata_d     = '0;
            last_d      = 1'b0;
          end
          pend_d     = 1'b1;
          pend_len_d = tot_q;
          good_len_d = tot_q;
          n_d        = n_q + NW'(1);
          s_d        = s_q + CW'(tot_q);
        end
      end
      xcfd_pkg::StFinish: begin
        if (!pend_q || slot_free) begin
          if (pend_q) begin
            out_valid_d = 1'b1;
            kind_d      = xcfd_pkg::KindFrame;
            flen_d      = 12'(pend_len_q);
            rdata_d     = '0;
            last_d      = 1'b1;
          end
          pend_d = 1'b0;
          if (s_q >= fill_q) begin
            fill_d = '0;
          end else begin
            head_d = head_q + s_q[AW-1:0];
            fill_d = fill_q - s_q;
          end
          s_d = '0;
          n_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= xcfd_pkg::StIdle;
      hf_q        <= xcfd_pkg::HeaderFirstRst;
      hs_q        <= xcfd_pkg::HeaderSecondRst;
      fill_q      <= '0;
      s_q         <= '0;
      head_q      <= '0;
      good_len_q  <= '0;
      pend_q      <= 1'b0;
      n_q         <= '0;
      cp_we_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      s_q         <= s_d;
      head_q      <= head_d;
      good_len_q  <= good_len_d;
      pend_q      <= pend_d;
      n_q         <= n_d;
      cp_we_q     <= cp_we_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_index_i == xcfd_pkg::CfgHeaderFirst) hf_q <= cfg_data_i;
        else hs_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    tot_q      <= tot_d;
    pend_len_q <= pend_len_d;
    len_hi_q   <= len_hi_d;
    acc_q      <= acc_d;
    ridx_q     <= ridx_d;
    cp_addr_q  <= cp_addr_d;
    kind_q     <= kind_d;
    flen_q     <= flen_d;
    rdata_q    <= rdata_d;
    last_q     <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign frame_length_o = flen_q;
  assign read_data_o    = rdata_q;
  assign last_o         = last_q;

endmodule

/* hw/rtl/xcfd_checker.sv */
// Port-level checker for the frame deframer core, bound to the top level.
// Depends on xcfd_pkg and xor_checked_frame_deframer_core.
module xcfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic [11:0] frame_length_o,
  input logic [7:0]  read_data_o,
  input logic        last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("transaction accepted while busy");

  a_read_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == xcfd_pkg::KindRead |-> last_o)
    else $error("read result not marked last");

  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == xcfd_pkg::KindOverflow |->
      frame_length_o == '0 && read_data_o == '0 && last_o)
    else $error("overflow result malformed");

  a_frame_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == xcfd_pkg::KindFrame |->
      frame_length_o >= 12'(xcfd_pkg::MinTotal) && read_data_o == '0)
    else $error("frame result malformed");

endmodule

bind xor_checked_frame_deframer_core xcfd_checker u_xcfd_checker (.*);
